// ===== rtl/core/aavt_pkg.sv =====
// ----------------------------------------------------------------------------
// aavt_pkg
// Shared types, constants and fixed-point helpers of the animated affine
// vertex transform: word format, config and payload structs, datapath codes.
// ----------------------------------------------------------------------------
package aavt_pkg;

	// number format
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 24;
	localparam int IO_BITS = 24;
	// multiplier operand a carries either a word or a vertex coordinate
	localparam int MUL_A_BITS = (WORD_BITS > IO_BITS) ? WORD_BITS : IO_BITS;
	localparam int PROD_BITS = MUL_A_BITS + WORD_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [IO_BITS-1:0] io_t;
	typedef logic signed [MUL_A_BITS-1:0] mul_a_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [WORD_BITS:0] wsum_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam io_t IO_MAX = {1'b0, {(IO_BITS-1){1'b1}}};
	localparam io_t IO_MIN = {1'b1, {(IO_BITS-1){1'b0}}};
	localparam word_t ONE_Q = word_t'(1) << FRAC_BITS;

	// configuration registers
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_STEP = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COSINE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SINE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_STEP = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_LOW = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_HIGH = 3'd5;

	typedef struct packed {
		logic signed [23:0] offset_step;
		logic signed [17:0] step_cosine;
		logic signed [17:0] step_sine;
		logic [16:0] scale_step;
		logic [22:0] scale_low;
		logic [22:0] scale_high;
	} cfg_t;

	localparam logic signed [23:0] RST_OFFSET_STEP = 24'sd66;
	localparam logic signed [17:0] RST_STEP_COSINE = 18'sd65526;
	localparam logic signed [17:0] RST_STEP_SINE = 18'sd1144;
	localparam logic [16:0] RST_SCALE_STEP = 17'd655;
	localparam logic [22:0] RST_SCALE_LOW = 23'd45875;
	localparam logic [22:0] RST_SCALE_HIGH = 23'd85197;

	// payload
	typedef struct packed {
		logic mode;
		io_t vertex_x;
		io_t vertex_y;
	} item_t;

	typedef struct packed {
		io_t out_x;
		io_t out_y;
	} result_t;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_VERTEX = 1'b1;

	// multiplier operand pairs
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_AC_BS = 3'd1;
	localparam logic [2:0] MUL_AS_BC = 3'd2;
	localparam logic [2:0] MUL_CC_DS = 3'd3;
	localparam logic [2:0] MUL_CS_DC = 3'd4;
	localparam logic [2:0] MUL_XS_YS = 3'd5;
	localparam logic [2:0] MUL_ASX_BSY = 3'd6;
	localparam logic [2:0] MUL_CSX_DSY = 3'd7;

	// what the registered products are combined into
	localparam logic [2:0] CMB_NONE = 3'd0;
	localparam logic [2:0] CMB_NA = 3'd1;
	localparam logic [2:0] CMB_NB = 3'd2;
	localparam logic [2:0] CMB_NC = 3'd3;
	localparam logic [2:0] CMB_ND = 3'd4;
	localparam logic [2:0] CMB_SXY = 3'd5;
	localparam logic [2:0] CMB_OX = 3'd6;
	localparam logic [2:0] CMB_OY = 3'd7;

	typedef struct packed {
		logic load_item;
		logic [2:0] mul_sel;
		logic [2:0] cmb;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// floor of product / 2^FRAC_BITS, saturated to the word range
	function automatic word_t sat_prod(input prod_t p);
		prod_t sh;
		logic all_one;
		logic all_zero;
		sh = p >>> FRAC_BITS;
		all_one = &sh[PROD_BITS-1:WORD_BITS-1];
		all_zero = ~|sh[PROD_BITS-1:WORD_BITS-1];
		if (all_one || all_zero) begin
			return sh[WORD_BITS-1:0];
		end else begin
			return sh[PROD_BITS-1] ? WORD_MIN : WORD_MAX;
		end
	endfunction

	// one bit of growth back to the word range
	function automatic word_t sat_sum(input wsum_t s);
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		end else begin
			return s[WORD_BITS-1:0];
		end
	endfunction

	function automatic wsum_t ext_word(input word_t w);
		return {w[WORD_BITS-1], w};
	endfunction

	// word to output range
	function automatic io_t clamp_io(input word_t w);
		logic all_one;
		logic all_zero;
		all_one = &w[WORD_BITS-1:IO_BITS-1];
		all_zero = ~|w[WORD_BITS-1:IO_BITS-1];
		if (all_one || all_zero) begin
			return w[IO_BITS-1:0];
		end else begin
			return w[WORD_BITS-1] ? IO_MIN : IO_MAX;
		end
	endfunction

endpackage

// ===== rtl/core/aavt_regs.sv =====
// ----------------------------------------------------------------------------
// aavt_regs
// APB-style register file holding the animation step settings.
// ----------------------------------------------------------------------------
module aavt_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [aavt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [aavt_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [aavt_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic pready,
	output aavt_pkg::cfg_t cfg
);

	aavt_pkg::cfg_t cfg_q;
	logic [aavt_pkg::CFG_INDEX_BITS-1:0] index;
	logic wr_en;

	assign index = paddr[aavt_pkg::CFG_ADDR_BITS-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_step <= aavt_pkg::RST_OFFSET_STEP;
			cfg_q.step_cosine <= aavt_pkg::RST_STEP_COSINE;
			cfg_q.step_sine <= aavt_pkg::RST_STEP_SINE;
			cfg_q.scale_step <= aavt_pkg::RST_SCALE_STEP;
			cfg_q.scale_low <= aavt_pkg::RST_SCALE_LOW;
			cfg_q.scale_high <= aavt_pkg::RST_SCALE_HIGH;
		end else if (wr_en) begin
			unique case (index)
				aavt_pkg::REG_OFFSET_STEP: cfg_q.offset_step <= pwdata[23:0];
				aavt_pkg::REG_STEP_COSINE: cfg_q.step_cosine <= pwdata[17:0];
				aavt_pkg::REG_STEP_SINE: cfg_q.step_sine <= pwdata[17:0];
				aavt_pkg::REG_SCALE_STEP: cfg_q.scale_step <= pwdata[16:0];
				aavt_pkg::REG_SCALE_LOW: cfg_q.scale_low <= pwdata[22:0];
				aavt_pkg::REG_SCALE_HIGH: cfg_q.scale_high <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			aavt_pkg::REG_OFFSET_STEP: prdata = 32'(cfg_q.offset_step);
			aavt_pkg::REG_STEP_COSINE: prdata = 32'(cfg_q.step_cosine);
			aavt_pkg::REG_STEP_SINE: prdata = 32'(cfg_q.step_sine);
			aavt_pkg::REG_SCALE_STEP: prdata = 32'(cfg_q.scale_step);
			aavt_pkg::REG_SCALE_LOW: prdata = 32'(cfg_q.scale_low);
			aavt_pkg::REG_SCALE_HIGH: prdata = 32'(cfg_q.scale_high);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/aavt_ctrl.sv =====
// ----------------------------------------------------------------------------
// aavt_ctrl
// Sequencer for tick and vertex items: steps the shared multiplier pair
// through its operand schedule and tells the datapath where results go.
// ----------------------------------------------------------------------------
module aavt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_mode,
	output logic item_ready,
	input  aavt_pkg::dp_status_t status,
	output aavt_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_T1 = 4'd1;
	localparam logic [3:0] ST_T2 = 4'd2;
	localparam logic [3:0] ST_T3 = 4'd3;
	localparam logic [3:0] ST_T4 = 4'd4;
	localparam logic [3:0] ST_T5 = 4'd5;
	localparam logic [3:0] ST_V1 = 4'd6;
	localparam logic [3:0] ST_V2 = 4'd7;
	localparam logic [3:0] ST_V3 = 4'd8;
	localparam logic [3:0] ST_V4 = 4'd9;
	localparam logic [3:0] ST_V5 = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_next;
	logic accept;

	assign item_ready = (state_q == ST_IDLE);
	assign accept = item_valid && item_ready;

	always_comb begin
		state_next = state_q;
		cmd.load_item = accept;
		cmd.mul_sel = aavt_pkg::MUL_NONE;
		cmd.cmb = aavt_pkg::CMB_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (item_mode == aavt_pkg::MODE_VERTEX) ? ST_V1 : ST_T1;
				end
			end
			ST_T1: begin
				cmd.mul_sel = aavt_pkg::MUL_AC_BS;
				state_next = ST_T2;
			end
			ST_T2: begin
				cmd.mul_sel = aavt_pkg::MUL_AS_BC;
				cmd.cmb = aavt_pkg::CMB_NA;
				state_next = ST_T3;
			end
			ST_T3: begin
				cmd.mul_sel = aavt_pkg::MUL_CC_DS;
				cmd.cmb = aavt_pkg::CMB_NB;
				state_next = ST_T4;
			end
			ST_T4: begin
				cmd.mul_sel = aavt_pkg::MUL_CS_DC;
				cmd.cmb = aavt_pkg::CMB_NC;
				state_next = ST_T5;
			end
			ST_T5: begin
				cmd.cmb = aavt_pkg::CMB_ND;
				state_next = ST_IDLE;
			end
			ST_V1: begin
				cmd.mul_sel = aavt_pkg::MUL_XS_YS;
				state_next = ST_V2;
			end
			ST_V2: begin
				cmd.cmb = aavt_pkg::CMB_SXY;
				state_next = ST_V3;
			end
			ST_V3: begin
				cmd.mul_sel = aavt_pkg::MUL_ASX_BSY;
				state_next = ST_V4;
			end
			ST_V4: begin
				cmd.mul_sel = aavt_pkg::MUL_CSX_DSY;
				cmd.cmb = aavt_pkg::CMB_OX;
				state_next = ST_V5;
			end
			ST_V5: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.cmb = aavt_pkg::CMB_OY;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== rtl/core/aavt_dp.sv =====
// ----------------------------------------------------------------------------
// aavt_dp
// Datapath: animation state, two shared multipliers with registered
// products, the floor/saturate/add stage and the output register.
// ----------------------------------------------------------------------------
module aavt_dp (
	input  logic clk,
	input  logic arst_n,
	input  aavt_pkg::cfg_t cfg,
	input  aavt_pkg::item_t item,
	input  aavt_pkg::dp_cmd_t cmd,
	output aavt_pkg::dp_status_t status,
	output logic result_valid,
	input  logic result_ready,
	output aavt_pkg::result_t result
);

	// animation state
	aavt_pkg::word_t x_offset_q;
	aavt_pkg::word_t rot_a_q;
	aavt_pkg::word_t rot_b_q;
	aavt_pkg::word_t rot_c_q;
	aavt_pkg::word_t rot_d_q;
	aavt_pkg::word_t scale_factor_q;
	aavt_pkg::word_t scale_tracker_q;
	logic growing_q;

	// per-item working registers
	aavt_pkg::io_t x_q;
	aavt_pkg::io_t y_q;
	aavt_pkg::word_t sx_q;
	aavt_pkg::word_t sy_q;
	aavt_pkg::word_t na_q;
	aavt_pkg::word_t nb_q;
	aavt_pkg::word_t nc_q;
	aavt_pkg::word_t ox_q;
	aavt_pkg::prod_t p0_q;
	aavt_pkg::prod_t p1_q;

	logic result_valid_q;
	aavt_pkg::result_t result_q;

	aavt_pkg::mul_a_t mul0_a;
	aavt_pkg::mul_a_t mul1_a;
	aavt_pkg::word_t mul0_b;
	aavt_pkg::word_t mul1_b;
	aavt_pkg::prod_t p0;
	aavt_pkg::prod_t p1;
	aavt_pkg::word_t m0;
	aavt_pkg::word_t m1;
	aavt_pkg::word_t sum_add;
	aavt_pkg::word_t sum_sub;
	aavt_pkg::word_t ox_full;
	aavt_pkg::word_t cos_w;
	aavt_pkg::word_t sin_w;
	aavt_pkg::word_t offset_next;
	aavt_pkg::word_t factor_next;
	aavt_pkg::word_t tracker_next;
	logic growing_next;
	aavt_pkg::wsum_t scale_step_ext;
	aavt_pkg::wsum_t tracker_ext;

	assign cos_w = aavt_pkg::WORD_BITS'(cfg.step_cosine);
	assign sin_w = aavt_pkg::WORD_BITS'(cfg.step_sine);

	// operand schedule
	always_comb begin
		mul0_a = '0;
		mul0_b = '0;
		mul1_a = '0;
		mul1_b = '0;
		unique case (cmd.mul_sel)
			aavt_pkg::MUL_AC_BS: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_a_q);
				mul0_b = cos_w;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_b_q);
				mul1_b = sin_w;
			end
			aavt_pkg::MUL_AS_BC: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_a_q);
				mul0_b = sin_w;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_b_q);
				mul1_b = cos_w;
			end
			aavt_pkg::MUL_CC_DS: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_c_q);
				mul0_b = cos_w;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_d_q);
				mul1_b = sin_w;
			end
			aavt_pkg::MUL_CS_DC: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_c_q);
				mul0_b = sin_w;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_d_q);
				mul1_b = cos_w;
			end
			aavt_pkg::MUL_XS_YS: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(x_q);
				mul0_b = scale_factor_q;
				mul1_a = aavt_pkg::MUL_A_BITS'(y_q);
				mul1_b = scale_factor_q;
			end
			aavt_pkg::MUL_ASX_BSY: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_a_q);
				mul0_b = sx_q;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_b_q);
				mul1_b = sy_q;
			end
			aavt_pkg::MUL_CSX_DSY: begin
				mul0_a = aavt_pkg::MUL_A_BITS'(rot_c_q);
				mul0_b = sx_q;
				mul1_a = aavt_pkg::MUL_A_BITS'(rot_d_q);
				mul1_b = sy_q;
			end
			default: ;
		endcase
	end

	assign p0 = mul0_a * mul0_b;
	assign p1 = mul1_a * mul1_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_sel != aavt_pkg::MUL_NONE) begin
			p0_q <= p0;
			p1_q <= p1;
		end
	end

	// floor, saturate, combine
	assign m0 = aavt_pkg::sat_prod(p0_q);
	assign m1 = aavt_pkg::sat_prod(p1_q);
	assign sum_add = aavt_pkg::sat_sum(aavt_pkg::ext_word(m0) + aavt_pkg::ext_word(m1));
	assign sum_sub = aavt_pkg::sat_sum(aavt_pkg::ext_word(m0) - aavt_pkg::ext_word(m1));
	assign ox_full = aavt_pkg::sat_sum(aavt_pkg::ext_word(sum_add)
		+ aavt_pkg::ext_word(x_offset_q));

	// offset and scale step of a tick
	assign scale_step_ext = aavt_pkg::wsum_t'(cfg.scale_step);

	always_comb begin
		offset_next = aavt_pkg::sat_sum(aavt_pkg::ext_word(x_offset_q)
			+ aavt_pkg::wsum_t'(cfg.offset_step));
		if (growing_q) begin
			factor_next = aavt_pkg::sat_sum(aavt_pkg::ext_word(scale_factor_q) + scale_step_ext);
			tracker_next = aavt_pkg::sat_sum(aavt_pkg::ext_word(scale_tracker_q)
				+ scale_step_ext);
		end else begin
			factor_next = aavt_pkg::sat_sum(aavt_pkg::ext_word(scale_factor_q) - scale_step_ext);
			tracker_next = aavt_pkg::sat_sum(aavt_pkg::ext_word(scale_tracker_q)
				- scale_step_ext);
		end
		tracker_ext = aavt_pkg::ext_word(tracker_next);
		// only the bound of the current direction is checked
		if (growing_q) begin
			growing_next = !(tracker_ext >= $signed(aavt_pkg::wsum_t'(cfg.scale_high)));
		end else begin
			growing_next = (tracker_ext <= $signed(aavt_pkg::wsum_t'(cfg.scale_low)));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q <= item.vertex_x;
			y_q <= item.vertex_y;
		end
		unique case (cmd.cmb)
			aavt_pkg::CMB_NA: na_q <= sum_sub;
			aavt_pkg::CMB_NB: nb_q <= sum_add;
			aavt_pkg::CMB_NC: nc_q <= sum_sub;
			aavt_pkg::CMB_SXY: begin
				sx_q <= m0;
				sy_q <= m1;
			end
			aavt_pkg::CMB_OX: ox_q <= ox_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
			rot_a_q <= aavt_pkg::ONE_Q;
			rot_b_q <= '0;
			rot_c_q <= '0;
			rot_d_q <= aavt_pkg::ONE_Q;
			scale_factor_q <= aavt_pkg::ONE_Q;
			scale_tracker_q <= aavt_pkg::WORD_BITS'(aavt_pkg::RST_SCALE_LOW);
			growing_q <= 1'b1;
		end else if (cmd.cmb == aavt_pkg::CMB_ND) begin
			x_offset_q <= offset_next;
			rot_a_q <= na_q;
			rot_b_q <= nb_q;
			rot_c_q <= nc_q;
			rot_d_q <= sum_add;
			scale_factor_q <= factor_next;
			scale_tracker_q <= tracker_next;
			growing_q <= growing_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.cmb == aavt_pkg::CMB_OY) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmb == aavt_pkg::CMB_OY) begin
			result_q.out_x <= aavt_pkg::clamp_io(ox_q);
			result_q.out_y <= aavt_pkg::clamp_io(sum_add);
		end
	end

	assign status.out_free = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/core/animated_affine_vertex_transform.sv =====
// ----------------------------------------------------------------------------
// animated_affine_vertex_transform
// Signed Q8.16 2D vertex transform with per-tick animation of offset,
// rotation and scale; vertices get translate * rotate * scale.
// ----------------------------------------------------------------------------
//  channel   handshake                          payload
//  item      item_valid / item_ready            item_t: mode, vertex_x, vertex_y
//  result    result_valid / result_ready        result_t: out_x, out_y
//  config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
//  one item at a time through a shared pair of multipliers: a tick runs from its
//  accept beat through four product pairs and then the final combine; a vertex
//  waits before its final combine for as long as the output register is not free.
//  item_ready is high only while the sequencer is idle; a pending result beat
//  does not block the next item until its own result is ready to load.
//  reset restores the register defaults and the start of the animation.
// ----------------------------------------------------------------------------
module animated_affine_vertex_transform (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  aavt_pkg::item_t item,
	output logic result_valid,
	input  logic result_ready,
	output aavt_pkg::result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [aavt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [aavt_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [aavt_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic pready
);

	aavt_pkg::cfg_t cfg;
	aavt_pkg::dp_cmd_t cmd;
	aavt_pkg::dp_status_t status;

	aavt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aavt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_mode  (item.mode),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	aavt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
